@@ rtl/ilie_pkg.sv @@
// Shared types and constants for the indexed list block.
package ilie_pkg;

    localparam int DEF_DEPTH       = 64;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int IN_VALUE_W      = 32;
    localparam int OFFSET_W        = 8;
    localparam int FUNC_W          = 3;
    // wide enough for a cell position at the largest supported depth (1024)
    localparam int POS_W           = 10;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT  = 3'd0,
        FN_ERASE   = 3'd1,
        FN_REVERSE = 3'd2,
        FN_FIND    = 3'd3,
        FN_CLEAR   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_ERASE
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [POS_W-1:0] pos;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIND,
        ST_DONE
    } t_state;

endpackage

@@ rtl/indexed_list_insert_erase_find.sv @@
// Top level of the indexed list: control FSM, cell chain and result register.
//
// Usage: one operation per input transfer (i_func, i_offset, i_value) on a
// valid/stall channel; o_stall is low only while the block is idle. Each
// operation yields exactly one result transfer on the output channel
// (o_found_index, o_entry_count, o_overflow, o_ignored), held stable while
// i_stall is high.
// The FSM steps IDLE -> EXEC -> DONE for insert, erase, reverse and clear,
// and IDLE -> EXEC -> FIND -> DONE for find (the extra FIND state does the
// priority pick over the registered match vector); DONE hands the result to
// the output register and raises o_valid. No new operation is taken before
// IDLE; a stall on the output only holds the block once a result is already waiting.
// The entries live in a chain of cells; insert and erase shift the cells from
// the target position onward by one neighbor. Reverse only flips a direction
// flag: logical positions are mapped onto physical cells through that flag.
// Reset clears the count, the direction flag, the FSM and the output valid;
// entry contents are not cleared (only live entries are ever read).
module indexed_list_insert_erase_find
    import ilie_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int AW          = $clog2(DEPTH),
    parameter int CW          = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [OFFSET_W-1:0]   i_offset,
    input  logic [IN_VALUE_W-1:0] i_value,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [AW:0]           o_found_index,
    output logic [CW-1:0]         o_entry_count,
    output logic                  o_overflow,
    output logic                  o_ignored
);

    // common width for offset vs count compares
    localparam int PW = (CW > OFFSET_W) ? CW : OFFSET_W;
    localparam logic [CW-1:0] FullCount = CW'(DEPTH);

    // ---------------- registers ----------------
    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    logic                   r_rev, n_rev;       // list stored in reversed order
    logic [FUNC_W-1:0]      r_func;
    logic [OFFSET_W-1:0]    r_offset;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [DEPTH-1:0]       r_match;
    // pending result, computed in EXEC or FIND
    logic [AW:0]            r_res_found, n_res_found;
    logic [CW-1:0]          r_res_count, n_res_count;
    logic                   r_res_ovf, n_res_ovf;
    logic                   r_res_ign, n_res_ign;
    // output register
    logic                   r_out_valid, n_out_valid;
    logic [AW:0]            r_out_found;
    logic [CW-1:0]          r_out_count;
    logic                   r_out_ovf;
    logic                   r_out_ign;

    logic                   in_xfer;
    logic                   out_xfer;
    logic                   out_load;
    t_cell_cmd              cell_cmd;
    logic [VALUE_WIDTH-1:0] in_val;

    // only the low VALUE_WIDTH bits of the value take part; a wider VALUE_WIDTH zero-extends it
    generate
        if (VALUE_WIDTH <= IN_VALUE_W) begin : g_val_narrow
            assign in_val = i_value[VALUE_WIDTH-1:0];
        end else begin : g_val_wide
            assign in_val = {{(VALUE_WIDTH - IN_VALUE_W){1'b0}}, i_value};
        end
    endgenerate

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    // ---------------- cell chain ----------------
    logic [VALUE_WIDTH-1:0] cell_q [DEPTH];
    logic [DEPTH-1:0]       cell_match;

    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [VALUE_WIDTH-1:0] left_d;
            logic [VALUE_WIDTH-1:0] right_d;
            if (g == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_mid_l
                assign left_d = cell_q[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_mid_r
                assign right_d = cell_q[g+1];
            end
            ilie_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .IDX         (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (cell_cmd),
                .i_left  (left_d),
                .i_right (right_d),
                .i_value (r_value),
                .o_entry (cell_q[g]),
                .o_match (cell_match[g])
            );
        end
    endgenerate

    // live-entry mask on the compare results
    logic [DEPTH-1:0] live_match;
    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_live
            assign live_match[g] = cell_match[g] && (CW'(g) < r_count);
        end
    endgenerate

    // ---------------- find pick ----------------
    logic          pick_any;
    logic [AW-1:0] pick_idx;
    logic [CW-1:0] logical_idx;

    ilie_pick #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_pick (
        .i_bits (r_match),
        .i_high (r_rev),
        .o_any  (pick_any),
        .o_idx  (pick_idx)
    );

    // reversed storage: physical cell i holds logical entry count-1-i
    assign logical_idx = r_rev ? (r_count - CW'(1) - CW'(pick_idx)) : CW'(pick_idx);

    // ---------------- position decode ----------------
    logic [PW-1:0] off_ext;
    logic [PW-1:0] cnt_ext;
    logic          off_past;
    logic [CW-1:0] ins_clamp;
    logic [CW-1:0] ins_pos;
    logic [CW-1:0] ers_pos;

    assign off_ext   = PW'(r_offset);
    assign cnt_ext   = PW'(r_count);
    assign off_past  = (off_ext >= cnt_ext);
    assign ins_clamp = off_past ? r_count : CW'(r_offset);
    assign ins_pos   = r_rev ? (r_count - ins_clamp) : ins_clamp;
    assign ers_pos   = r_rev ? (r_count - CW'(1) - CW'(r_offset)) : CW'(r_offset);

    // ---------------- next state and control ----------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rev       = r_rev;
        n_res_found = r_res_found;
        n_res_count = r_res_count;
        n_res_ovf   = r_res_ovf;
        n_res_ign   = r_res_ign;
        cell_cmd.op  = CELL_HOLD;
        cell_cmd.pos = '0;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && !out_xfer;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_res_found = '1;
                n_res_ovf   = 1'b0;
                n_res_ign   = 1'b0;
                n_state     = ST_DONE;
                case (r_func)
                    FN_INSERT: begin
                        if (r_count == FullCount) begin
                            n_res_ovf = 1'b1;
                        end else begin
                            cell_cmd.op  = CELL_INSERT;
                            cell_cmd.pos = POS_W'(ins_pos);
                            n_count      = r_count + CW'(1);
                        end
                    end
                    FN_ERASE: begin
                        if (off_past) begin
                            n_res_ign = 1'b1;
                        end else begin
                            cell_cmd.op  = CELL_ERASE;
                            cell_cmd.pos = POS_W'(ers_pos);
                            n_count      = r_count - CW'(1);
                        end
                    end
                    FN_REVERSE: n_rev = ~r_rev;
                    FN_FIND:    n_state = ST_FIND;
                    FN_CLEAR: begin
                        n_count = '0;
                        n_rev   = 1'b0;
                    end
                    default: n_state = ST_DONE;
                endcase
                n_res_count = n_count;
            end
            ST_FIND: begin
                n_res_found = pick_any ? {1'b0, AW'(logical_idx)} : '1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || out_xfer) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rev       <= n_rev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func   <= i_func;
            r_offset <= i_offset;
            r_value  <= in_val;
        end
        if (r_state == ST_EXEC) begin
            r_match <= live_match;
        end
        r_res_found <= n_res_found;
        r_res_count <= n_res_count;
        r_res_ovf   <= n_res_ovf;
        r_res_ign   <= n_res_ign;
        if (out_load) begin
            r_out_found <= r_res_found;
            r_out_count <= r_res_count;
            r_out_ovf   <= r_res_ovf;
            r_out_ign   <= r_res_ign;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found_index = r_out_found;
    assign o_entry_count = r_out_count;
    assign o_overflow    = r_out_ovf;
    assign o_ignored     = r_out_ign;

    // ---------------- assertions ----------------
    // live count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCount)
        else $error("live count exceeds capacity");

    // a dropped insert is only reported on a full list
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow |-> o_entry_count == FullCount)
        else $error("overflow reported on a list that is not full");

    // a found index always points at a live entry
    a_found_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found_index[AW] |-> CW'(o_found_index[AW-1:0]) < o_entry_count)
        else $error("found index outside the live entries");

    // the block takes one operation at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_stall)
        else $error("input accepted while an operation is in flight");

    // overflow and ignored flags never come together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_overflow && o_ignored))
        else $error("overflow and ignored both set");

endmodule

@@ rtl/ilie_cell.sv @@
// One storage cell of the list chain: holds one entry, shifts with its neighbors.
module ilie_cell
    import ilie_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int IDX         = 0
) (
    input  logic                   i_clk,
    input  t_cell_cmd              i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_left,
    input  logic [VALUE_WIDTH-1:0] i_right,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic [VALUE_WIDTH-1:0] o_entry,
    output logic                   o_match
);

    localparam logic [POS_W-1:0] MyPos = POS_W'(IDX);

    logic [VALUE_WIDTH-1:0] r_entry;
    logic [VALUE_WIDTH-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            CELL_INSERT: begin
                if (MyPos > i_cmd.pos) begin
                    n_entry = i_left;
                end else if (MyPos == i_cmd.pos) begin
                    n_entry = i_value;
                end
            end
            CELL_ERASE: begin
                if (MyPos >= i_cmd.pos) begin
                    n_entry = i_right;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_value);

endmodule

@@ rtl/ilie_pick.sv @@
// Priority pick over the registered match vector: lowest or highest set bit.
module ilie_pick
    import ilie_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic [DEPTH-1:0] i_bits,
    input  logic             i_high,
    output logic             o_any,
    output logic [AW-1:0]    o_idx
);

    always_comb begin
        o_idx = '0;
        o_any = |i_bits;
        for (int i = 0; i < DEPTH; i++) begin
            if (i_high) begin
                if (i_bits[i]) o_idx = AW'(i);
            end else begin
                if (i_bits[DEPTH-1-i]) o_idx = AW'(DEPTH-1-i);
            end
        end
    end

endmodule
